### design/dett_pkg.sv
// ----------------------------------------------------------------------------
// dett_pkg
// Shared constants, register indexes and saturation helper for the detent
// encoder target tracker.
// ----------------------------------------------------------------------------
package dett_pkg;

	// configuration register indexes
	localparam logic [2:0] CFG_MAX_DELTA    = 3'd0;
	localparam logic [2:0] CFG_REVERSE_DIR  = 3'd1;
	localparam logic [2:0] CFG_COUNTS_PER   = 3'd2;
	localparam logic [2:0] CFG_STEP_TURNS   = 3'd3;
	localparam logic [2:0] CFG_SPEED_PER    = 3'd4;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;

	// register reset values
	localparam logic [15:0] MAX_DELTA_RST  = 16'd1000;
	localparam logic [7:0]  COUNTS_PER_RST = 8'd4;
	localparam logic [31:0] STEP_TURNS_RST = 32'd1820;
	localparam logic [30:0] SPEED_PER_RST  = 31'd5898240;

	localparam logic OP_INIT   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	// serial divider: 18-bit dividend magnitude, 8-bit divisor
	localparam int unsigned DIV_N_W   = 18;
	localparam int unsigned DIV_D_W   = 8;
	localparam int unsigned DIV_CNT_W = 5;
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_N_W - 1);

	localparam int unsigned PROD_W = 50;
	localparam int unsigned SAT_W  = 52;

	// clamp a wide signed value into signed 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
		logic signed [SAT_W-1:0] hi;
		logic signed [SAT_W-1:0] lo;
		hi = $signed({{(SAT_W-32){1'b0}}, 32'h7fff_ffff});
		lo = $signed({{(SAT_W-32){1'b1}}, 32'h8000_0000});
		if (v > hi) begin
			return 32'sh7fff_ffff;
		end else if (v < lo) begin
			return 32'sh8000_0000;
		end else begin
			return $signed(v[31:0]);
		end
	endfunction

endpackage

### design/detent_encoder_target_tracker_core.sv
// ----------------------------------------------------------------------------
// detent_encoder_target_tracker_core
// Quadrature counter to detent steps, knob target tracking and speed report.
// ----------------------------------------------------------------------------
// One item is in work at a time; in_stall is high from the accept until the
// result is placed in the output register. An init item or a sample before
// init goes from the accept straight to the output load in ST_DONE, and a
// zero or out-of-range delta passes through ST_CHECK first. A sample that
// moves the count takes a check, the restoring divider (one quotient bit per
// cycle) and the ST_MUL_SPD and ST_MUL_STEP states on the shared 18x32
// multiplier. With no whole detent step the output load follows; with a
// step, the target and reference updates come before the output load. The
// next item can be taken in the cycle after the load, even while the result
// still waits behind out_stall; a result that finds the output register full
// holds until the pending beat is taken.
module detent_encoder_target_tracker_core
	import dett_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// input channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  op,
	input  logic [31:0]           counter_value,
	input  logic signed [31:0]    current_turns,
	input  logic                  position_mode,
	input  logic                  ref_is_zero,
	// output channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic signed [31:0]    speed,
	output logic                  ref_valid,
	output logic signed [31:0]    ref_offset,
	output logic signed [31:0]    target_turns,
	output logic signed [31:0]    pulse_count
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_MUL_SPD,
		ST_MUL_STEP,
		ST_TGT,
		ST_REF,
		ST_DONE
	} state_t;

	state_t state_q;

	// configuration registers
	logic [15:0]        max_delta_q;
	logic               reverse_q;
	logic [7:0]         cpd_q;
	logic signed [31:0] step_turns_q;
	logic [30:0]        spc_q;

	// tracker state
	logic [31:0]        last_count_q;
	logic signed [16:0] rem_q;
	logic [31:0]        pulses_q;
	logic signed [31:0] target_q;
	logic               ready_q;

	// per-item work registers
	logic signed [31:0] delta_q;
	logic signed [31:0] cur_q;
	logic               resync_q;
	logic signed [16:0] d17_q;
	logic               neg_q;
	logic [DIV_N_W-1:0] quo_q;
	logic [DIV_D_W-1:0] racc_q;
	logic [DIV_D_W-1:0] dvs_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic signed [17:0] steps_q;
	logic signed [PROD_W-1:0] prod_q;

	// staged result
	logic signed [31:0] res_speed_q;
	logic               res_valid_q;
	logic signed [31:0] res_ref_q;

	// output register
	logic               out_valid_q;
	logic signed [31:0] speed_q;
	logic               ref_valid_q;
	logic signed [31:0] ref_offset_q;
	logic signed [31:0] target_turns_q;
	logic [31:0]        pulse_count_q;

	logic in_accept;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;

	// check-stage arithmetic
	logic [31:0]        abs_delta;
	logic               too_big;
	logic signed [16:0] d17_dir;
	logic signed [17:0] sum18;
	logic [DIV_N_W-1:0] sum_mag;
	assign abs_delta = delta_q[31] ? (32'd0 - delta_q) : delta_q;
	assign too_big   = abs_delta > {16'd0, max_delta_q};
	assign d17_dir   = reverse_q ? (17'sd0 - delta_q[16:0]) : delta_q[16:0];
	assign sum18     = {rem_q[16], rem_q} + {d17_dir[16], d17_dir};
	assign sum_mag   = sum18[17] ? DIV_N_W'(18'sd0 - sum18) : DIV_N_W'(sum18);

	// one divider step
	logic [DIV_D_W:0]   trial;
	logic               q_bit;
	assign trial = {racc_q, quo_q[DIV_N_W-1]};
	assign q_bit = trial >= {1'b0, dvs_q};

	// shared multiplier
	logic signed [17:0]       mul_a;
	logic signed [31:0]       mul_b;
	logic signed [PROD_W-1:0] mul_p;
	always_comb begin
		if (state_q == ST_MUL_SPD) begin
			mul_a = {d17_q[16], d17_q};
			mul_b = $signed({1'b0, spc_q});
		end else begin
			mul_a = steps_q;
			mul_b = step_turns_q;
		end
	end
	assign mul_p = mul_a * mul_b;

	logic signed [31:0]      tgt_base;
	logic signed [SAT_W-1:0] tgt_sum;
	logic signed [SAT_W-1:0] ref_diff;
	assign tgt_base = resync_q ? cur_q : target_q;
	assign tgt_sum  = {{(SAT_W-32){tgt_base[31]}}, tgt_base}
	                + {{(SAT_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
	assign ref_diff = {{(SAT_W-32){target_q[31]}}, target_q}
	                - {{(SAT_W-32){cur_q[31]}}, cur_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_delta_q  <= MAX_DELTA_RST;
			reverse_q    <= 1'b0;
			cpd_q        <= COUNTS_PER_RST;
			step_turns_q <= $signed(STEP_TURNS_RST);
			spc_q        <= SPEED_PER_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_MAX_DELTA:   max_delta_q  <= cfg_data[15:0];
				CFG_REVERSE_DIR: reverse_q    <= cfg_data[0];
				CFG_COUNTS_PER:  cpd_q        <= cfg_data[7:0];
				CFG_STEP_TURNS:  step_turns_q <= $signed(cfg_data);
				CFG_SPEED_PER:   spc_q        <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			last_count_q <= '0;
			rem_q        <= '0;
			pulses_q     <= '0;
			target_q     <= '0;
			ready_q      <= 1'b0;
			out_valid_q  <= 1'b0;
			div_cnt_q    <= '0;
		end else begin
			// the output load below refills the register in the same cycle
			if (out_valid_q && !out_stall && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						res_speed_q <= '0;
						res_valid_q <= 1'b0;
						res_ref_q   <= '0;
						cur_q       <= current_turns;
						resync_q    <= !position_mode || ref_is_zero;
						if (op == OP_INIT) begin
							last_count_q <= '0;
							rem_q        <= '0;
							pulses_q     <= '0;
							target_q     <= current_turns;
							ready_q      <= 1'b1;
							state_q      <= ST_DONE;
						end else if (!ready_q) begin
							state_q <= ST_DONE;
						end else begin
							delta_q      <= $signed(counter_value - last_count_q);
							last_count_q <= counter_value;
							state_q      <= ST_CHECK;
						end
					end
				end
				ST_CHECK: begin
					priority if (delta_q == 32'sd0) begin
						state_q <= ST_DONE;
					end else if (too_big) begin
						rem_q   <= '0;
						state_q <= ST_DONE;
					end else begin
						d17_q     <= d17_dir;
						pulses_q  <= pulses_q + {{15{d17_dir[16]}}, d17_dir};
						neg_q     <= sum18[17];
						quo_q     <= sum_mag;
						racc_q    <= '0;
						dvs_q     <= (cpd_q == 8'd0) ? 8'd1 : cpd_q;
						div_cnt_q <= '0;
						state_q   <= ST_DIV;
					end
				end
				ST_DIV: begin
					// shift in one dividend bit, subtract when it fits
					racc_q    <= q_bit ? DIV_D_W'(trial - {1'b0, dvs_q})
					                   : DIV_D_W'(trial);
					quo_q     <= {quo_q[DIV_N_W-2:0], q_bit};
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == DIV_LAST) begin
						state_q <= ST_MUL_SPD;
					end
				end
				ST_MUL_SPD: begin
					// restore the sign of the truncated quotient and remainder
					steps_q <= neg_q ? (18'sd0 - $signed(quo_q)) : $signed(quo_q);
					rem_q   <= neg_q ? (17'sd0 - $signed({9'd0, racc_q}))
					                 : $signed({9'd0, racc_q});
					prod_q  <= mul_p;
					state_q <= ST_MUL_STEP;
				end
				ST_MUL_STEP: begin
					res_speed_q <= sat32({{(SAT_W-PROD_W){prod_q[PROD_W-1]}}, prod_q});
					if (steps_q == 18'sd0) begin
						state_q <= ST_DONE;
					end else begin
						prod_q  <= mul_p;
						state_q <= ST_TGT;
					end
				end
				ST_TGT: begin
					target_q <= sat32(tgt_sum);
					state_q  <= ST_REF;
				end
				ST_REF: begin
					res_ref_q   <= sat32(ref_diff);
					res_valid_q <= 1'b1;
					state_q     <= ST_DONE;
				end
				ST_DONE: begin
					// hold until the output register is free
					if (!out_valid_q || !out_stall) begin
						out_valid_q    <= 1'b1;
						speed_q        <= res_speed_q;
						ref_valid_q    <= res_valid_q;
						ref_offset_q   <= res_ref_q;
						target_turns_q <= target_q;
						pulse_count_q  <= pulses_q;
						state_q        <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign speed        = speed_q;
	assign ref_valid    = ref_valid_q;
	assign ref_offset   = ref_offset_q;
	assign target_turns = target_turns_q;
	assign pulse_count  = $signed(pulse_count_q);

	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (div_cnt_q <= DIV_LAST))
		else $error("divider step count out of range");

	a_ready_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(ready_q))
		else $error("ready dropped after init");

	a_ref_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_REF) |=> (state_q == ST_DONE && res_valid_q))
		else $error("reference update did not reach the output load");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result beat raised outside the output load");

endmodule
